### src/sps_pkg.sv
// Shared types and constants for the segmented prime sieve.
package sps_pkg;

    localparam int KEY_W = 40;   // candidate, heap key and count width
    localparam int CFG_W = 40;
    localparam int IN_W  = 8;
    localparam int OUT_W = 80;
    localparam int USR_W = 2;

    localparam logic [KEY_W-1:0] LIMIT_RST = KEY_W'(100000000);
    localparam logic [KEY_W-1:0] CAND_RST  = KEY_W'(3);
    localparam logic [KEY_W-1:0] COUNT_RST = KEY_W'(1);

    typedef enum logic [3:0] {
        ST_CLEAR,    // ring clearing pass
        ST_IDLE,
        ST_TEST,     // read heap root and ring bit
        ST_CHK,
        ST_MUL,      // p*p for a new base prime
        ST_POP_RD,
        ST_POP_LD,
        ST_DN_RDL,
        ST_DN_RDR,
        ST_DN_CMP,
        ST_MARK,
        ST_UP_RD,
        ST_UP_CMP,
        ST_FIN
    } t_state;

endpackage

### src/segmented_prime_sieve.sv
// Segmented prime sieve: heap of base-prime multiples plus a ring of composite marks.
//
// Input beat on the s channel (tdata bit 0 = restart) tests the next odd candidate,
// starting at 3; a restart beat first resets heap, ring and count. Each input beat
// yields exactly one output beat on the m channel. The limit register is written on
// the cfg channel and is used clamped to BASE_PRIME_BOUND squared.
// A beat passes through test, check and finish when the candidate hits no heap entry.
// A heap hit adds the start of the pop, sift-down levels (read left, read right,
// compare), the writing of composite marks plus the end of the marking, sift-up levels
// on reinsertion (read, compare), and a new test of the heap root (the heap and ring
// memories each have one read port, both with registered read). A new base prime adds
// a multiply step and a sift-up.
// The block takes one beat at a time: s_tready is high only in idle.
// After reset and after a restart beat, a clearing pass writes every ring bit, during
// which no beat is taken (cfg writes still are).
// A finished result waits in the output register while the m side stalls; the
// block holds the next result until that one is taken.
module segmented_prime_sieve #(
    parameter int BASE_PRIME_BOUND = 1000000,
    parameter int HEAP_DEPTH       = 131072,
    parameter int RING_BITS        = 4194304   // power of two
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_s_tvalid,
    output logic                       o_s_tready,
    input  logic [sps_pkg::IN_W-1:0]   i_s_tdata,   // [0] restart
    output logic                       o_m_tvalid,
    input  logic                       i_m_tready,
    output logic [sps_pkg::OUT_W-1:0]  o_m_tdata,   // [39:0] candidate, [79:40] prime_count
    output logic [sps_pkg::USR_W-1:0]  o_m_tuser,   // [0] is_prime, [1] done_res
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [sps_pkg::CFG_W-1:0]  i_cfg_data   // upper_limit
);
    import sps_pkg::*;

    localparam int HA     = $clog2(HEAP_DEPTH);
    localparam int SW     = $clog2(HEAP_DEPTH + 1);
    localparam int RA     = $clog2(RING_BITS);
    localparam int BW     = $clog2(BASE_PRIME_BOUND);
    localparam int STW    = $clog2(2 * BASE_PRIME_BOUND);
    localparam int EW     = KEY_W + STW;
    localparam int MW     = KEY_W + 1;
    localparam logic [63:0] SQ64 = 64'(BASE_PRIME_BOUND) * 64'(BASE_PRIME_BOUND);
    localparam logic [MW-1:0] SQ  = SQ64[MW-1:0];
    localparam logic [MW-1:0] WIN = MW'(2 * RING_BITS);
    localparam logic [SW-1:0] DEPTH_S = SW'(HEAP_DEPTH);
    localparam logic [KEY_W-1:0] BOUND_K = KEY_W'(BASE_PRIME_BOUND);

    t_state r_state, n_state;

    logic [SW-1:0]    r_size, n_size;
    logic [HA-1:0]    r_idx, n_idx;
    logic [KEY_W-1:0] r_cand, n_cand, r_count, n_count, r_limit;
    logic [KEY_W-1:0] r_cur_key, n_cur_key, r_ch_key, n_ch_key;
    logic [STW-1:0]   r_cur_st, n_cur_st, r_ch_st, n_ch_st, r_st, n_st;
    logic [MW-1:0]    r_m, n_m, r_stop, n_stop;
    logic             r_comp, n_comp, r_clr_ret, n_clr_ret;
    logic [RA:0]      r_clr, n_clr;
    logic             r_prime, n_prime, r_done, n_done;
    logic             r_ov, n_ov;
    logic [KEY_W-1:0] r_o_cand, r_o_count;
    logic             r_o_prime, r_o_done;

    // memories
    logic [EW-1:0] heap_mem [HEAP_DEPTH];
    logic          ring_mem [RING_BITS];
    logic [EW-1:0] r_hp_rd;
    logic          r_rg_rd;
    logic          hp_we, rg_we, rg_wd;
    logic [HA-1:0] hp_wa, hp_ra;
    logic [EW-1:0] hp_wd;
    logic [RA-1:0] rg_wa, rg_ra;

    logic [KEY_W-1:0] rd_key;
    logic [STW-1:0]   rd_st;
    logic [KEY_W-1:0] lim;
    logic [SW:0]      c_l, c_r;
    logic             has_l, has_r, pick_r;
    logic [MW-1:0]    m_next;
    logic [BW-1:0]    x_b;
    logic [2*BW-1:0]  prod;
    logic             root_hit, push_ok, out_free;
    logic [HA-1:0]    par;

    assign rd_key  = r_hp_rd[EW-1:STW];
    assign rd_st   = r_hp_rd[STW-1:0];
    assign lim     = (MW'(r_limit) > SQ) ? SQ[KEY_W-1:0] : r_limit;
    assign c_l     = (SW+1)'({r_idx, 1'b1});
    assign c_r     = c_l + (SW+1)'(1);
    assign has_l   = c_l < (SW+1)'(r_size);
    assign has_r   = c_r < (SW+1)'(r_size);
    assign pick_r  = has_r && (rd_key < r_ch_key);
    assign m_next  = r_m + MW'(r_st);
    assign x_b     = r_cand[BW-1:0];
    assign prod    = (2*BW)'(x_b) * (2*BW)'(x_b);
    assign root_hit = (r_size != '0) && (rd_key == r_cand);
    assign push_ok = r_size < DEPTH_S;
    assign out_free = !r_ov || i_m_tready;
    assign par     = HA'((r_idx - HA'(1)) >> 1);

    assign o_s_tready  = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_m_tvalid  = r_ov;
    assign o_m_tdata   = {r_o_count, r_o_cand};
    assign o_m_tuser   = {r_o_done, r_o_prime};

    always_ff @(posedge i_clk) begin
        if (hp_we) begin
            heap_mem[hp_wa] <= hp_wd;
        end
        r_hp_rd <= heap_mem[hp_ra];
    end

    always_ff @(posedge i_clk) begin
        if (rg_we) begin
            ring_mem[rg_wa] <= rg_wd;
        end
        r_rg_rd <= ring_mem[rg_ra];
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR:  if (r_clr == (RA+1)'(RING_BITS - 1)) begin
                n_state = r_clr_ret ? ST_TEST : ST_IDLE;
            end
            ST_IDLE:   if (i_s_tvalid) begin
                n_state = i_s_tdata[0] ? ST_CLEAR : ST_TEST;
            end
            ST_TEST:   n_state = (r_cand > lim) ? ST_FIN : ST_CHK;
            ST_CHK: begin
                if (root_hit) begin
                    n_state = ST_POP_RD;
                end else if (!r_comp && !r_rg_rd && r_cand < BOUND_K) begin
                    n_state = ST_MUL;
                end else begin
                    n_state = ST_FIN;
                end
            end
            ST_MUL:    n_state = push_ok ? ST_UP_RD : ST_FIN;
            ST_POP_RD: n_state = (r_size == SW'(1)) ? ST_MARK : ST_POP_LD;
            ST_POP_LD: n_state = ST_DN_RDL;
            ST_DN_RDL: n_state = has_l ? ST_DN_RDR : ST_MARK;
            ST_DN_RDR: n_state = ST_DN_CMP;
            ST_DN_CMP: begin
                if ((pick_r ? rd_key : r_ch_key) >= r_cur_key) begin
                    n_state = ST_MARK;
                end else begin
                    n_state = ST_DN_RDL;
                end
            end
            ST_MARK: begin
                if (m_next >= r_stop) begin
                    n_state = (m_next < SQ && push_ok) ? ST_UP_RD : ST_TEST;
                end
            end
            ST_UP_RD: begin
                if (r_idx == '0) begin
                    n_state = r_comp ? ST_TEST : ST_FIN;
                end else begin
                    n_state = ST_UP_CMP;
                end
            end
            ST_UP_CMP: begin
                if (rd_key <= r_cur_key) begin
                    n_state = r_comp ? ST_TEST : ST_FIN;
                end else begin
                    n_state = ST_UP_RD;
                end
            end
            ST_FIN:    if (out_free) begin
                n_state = ST_IDLE;
            end
            default:   n_state = ST_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb begin
        n_size = r_size;  n_idx = r_idx;  n_cand = r_cand;  n_count = r_count;
        n_cur_key = r_cur_key;  n_cur_st = r_cur_st;
        n_ch_key = r_ch_key;    n_ch_st = r_ch_st;
        n_m = r_m;  n_st = r_st;  n_stop = r_stop;  n_comp = r_comp;
        n_clr = r_clr;  n_clr_ret = r_clr_ret;
        n_prime = r_prime;  n_done = r_done;
        n_ov = r_ov && !i_m_tready;
        hp_we = 1'b0;  hp_wa = r_idx;  hp_wd = {r_cur_key, r_cur_st};  hp_ra = '0;
        rg_we = 1'b0;  rg_wa = r_clr[RA-1:0];  rg_wd = 1'b0;  rg_ra = r_cand[RA:1];
        unique case (r_state)
            ST_CLEAR: begin
                rg_we = 1'b1;
                n_clr = r_clr + (RA+1)'(1);
            end
            ST_IDLE: begin
                n_comp = 1'b0;  n_prime = 1'b0;  n_done = 1'b0;
                if (i_s_tvalid && i_s_tdata[0]) begin
                    n_size = '0;  n_cand = CAND_RST;  n_count = COUNT_RST;
                    n_clr = '0;   n_clr_ret = 1'b1;
                end
            end
            ST_TEST: begin
                hp_ra = '0;
                rg_ra = r_cand[RA:1];
                n_done = (r_cand > lim);
            end
            ST_CHK: begin
                if (root_hit) begin
                    n_comp = 1'b1;
                    n_m = MW'(rd_key);  n_st = rd_st;
                    n_stop = (MW'(r_cand) + WIN > SQ) ? SQ : MW'(r_cand) + WIN;
                end else if (!r_comp && !r_rg_rd) begin
                    n_prime = 1'b1;
                    n_count = r_count + KEY_W'(1);
                end else begin
                    rg_we = 1'b1;  rg_wa = r_cand[RA:1];  rg_wd = 1'b0;
                end
            end
            ST_MUL: begin
                n_cur_key = KEY_W'(prod);
                n_cur_st  = STW'({x_b, 1'b0});
                if (push_ok) begin
                    n_idx = r_size[HA-1:0];
                    n_size = r_size + SW'(1);
                end
            end
            ST_POP_RD: begin
                n_size = r_size - SW'(1);
                hp_ra = HA'(r_size - SW'(1));
            end
            ST_POP_LD: begin
                n_cur_key = rd_key;  n_cur_st = rd_st;  n_idx = '0;
            end
            ST_DN_RDL: begin
                hp_ra = c_l[HA-1:0];
                if (!has_l) begin
                    hp_we = 1'b1;
                end
            end
            ST_DN_RDR: begin
                n_ch_key = rd_key;  n_ch_st = rd_st;
                hp_ra = c_r[HA-1:0];
            end
            ST_DN_CMP: begin
                hp_we = 1'b1;
                if ((pick_r ? rd_key : r_ch_key) >= r_cur_key) begin
                    hp_wd = {r_cur_key, r_cur_st};
                end else begin
                    hp_wd = pick_r ? {rd_key, rd_st} : {r_ch_key, r_ch_st};
                    n_idx = pick_r ? c_r[HA-1:0] : c_l[HA-1:0];
                end
            end
            ST_MARK: begin
                n_m = m_next;
                if (m_next < r_stop) begin
                    rg_we = 1'b1;  rg_wa = m_next[RA:1];  rg_wd = 1'b1;
                end else if (m_next < SQ && push_ok) begin
                    n_cur_key = m_next[KEY_W-1:0];  n_cur_st = r_st;
                    n_idx = r_size[HA-1:0];
                    n_size = r_size + SW'(1);
                end
            end
            ST_UP_RD: begin
                hp_ra = par;
                if (r_idx == '0) begin
                    hp_we = 1'b1;
                end
            end
            ST_UP_CMP: begin
                hp_we = 1'b1;
                if (rd_key > r_cur_key) begin
                    hp_wd = {rd_key, rd_st};
                    n_idx = par;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    n_ov = 1'b1;
                    if (!r_done) begin
                        n_cand = r_cand + KEY_W'(2);
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_size  <= '0;
            r_cand  <= CAND_RST;
            r_count <= COUNT_RST;
            r_limit <= LIMIT_RST;
            r_clr   <= '0;
            r_clr_ret <= 1'b0;
            r_comp  <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_size  <= n_size;
            r_cand  <= n_cand;
            r_count <= n_count;
            r_clr   <= n_clr;
            r_clr_ret <= n_clr_ret;
            r_comp  <= n_comp;
            r_ov    <= n_ov;
            if (i_cfg_valid) begin
                r_limit <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx     <= n_idx;
        r_cur_key <= n_cur_key;
        r_cur_st  <= n_cur_st;
        r_ch_key  <= n_ch_key;
        r_ch_st   <= n_ch_st;
        r_m       <= n_m;
        r_st      <= n_st;
        r_stop    <= n_stop;
        r_prime   <= n_prime;
        r_done    <= n_done;
        if (r_state == ST_FIN && out_free) begin
            r_o_cand  <= r_cand;
            r_o_count <= r_count;
            r_o_prime <= r_prime;
            r_o_done  <= r_done;
        end
    end

    a_heap_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_size <= DEPTH_S) else $error("heap size past depth");

    a_done_not_prime: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && r_o_done |-> !r_o_prime) else $error("done result flagged prime");

    a_count_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_TEST |=> r_count == $past(r_count))
        else $error("count changed during test read");

    a_restart_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready && i_s_tdata[0] |=> r_state == ST_CLEAR && r_size == '0)
        else $error("restart did not clear");

endmodule
